// ----- sv/erp_pkg.sv -----
// shared types, constants and arithmetic helpers for the euler rotate / project block
// no dependencies; imported by every module of the block
package erp_pkg;

    // config register indexes
    typedef enum logic [2:0] {
        REG_ANGLE_X       = 3'd0,
        REG_ANGLE_Y       = 3'd1,
        REG_ANGLE_Z       = 3'd2,
        REG_VIEW_DISTANCE = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5
    } cfg_reg_t;

    localparam int CORDIC_STEPS = 16;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // quotient bits below the saturation check
    localparam int QUOT_BITS  = 17;
    localparam int DIV_STAGES = QUOT_BITS + 1;
    localparam int MAG_W      = 41;
    localparam int DEN_W      = 21;

    typedef logic signed [17:0] coord_t;
    typedef logic signed [15:0] trig_val_t;

    typedef struct packed {
        trig_val_t sin_x;
        trig_val_t cos_x;
        trig_val_t sin_y;
        trig_val_t cos_y;
        trig_val_t sin_z;
        trig_val_t cos_z;
    } trig_set_t;

    typedef struct packed {
        coord_t first;
        coord_t second;
    } rot_pair_t;

    // control that rides along the projection and divide stages
    typedef struct packed {
        logic valid;
        logic invalid;
        logic neg_x;
        logic neg_y;
    } proj_ctl_t;

    // cordic arctangent table, 2^24 units per turn
    function automatic logic [21:0] atan_lut(input logic [3:0] idx);
        logic [21:0] v;
        case (idx)
            4'd0:    v = 22'd2097152;
            4'd1:    v = 22'd1238021;
            4'd2:    v = 22'd654136;
            4'd3:    v = 22'd332050;
            4'd4:    v = 22'd166669;
            4'd5:    v = 22'd83416;
            4'd6:    v = 22'd41718;
            4'd7:    v = 22'd20860;
            4'd8:    v = 22'd10430;
            4'd9:    v = 22'd5215;
            4'd10:   v = 22'd2608;
            4'd11:   v = 22'd1304;
            4'd12:   v = 22'd652;
            4'd13:   v = 22'd326;
            4'd14:   v = 22'd163;
            4'd15:   v = 22'd81;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // (a*c - b*s, a*s + b*c), each rounded half up from q.26 back to q.12
    function automatic rot_pair_t rot_pair(input coord_t a, input coord_t b,
                                           input trig_val_t s, input trig_val_t c);
        logic signed [35:0] ae;
        logic signed [35:0] be;
        logic signed [35:0] se;
        logic signed [35:0] ce;
        logic signed [35:0] f;
        logic signed [35:0] g;
        rot_pair_t r;
        ae = a;
        be = b;
        se = s;
        ce = c;
        f = ae * ce - be * se + 36'sd8192;
        g = ae * se + be * ce + 36'sd8192;
        r.first  = f[31:14];
        r.second = g[31:14];
        return r;
    endfunction

    // truncated quotient magnitude with sign to a saturated 16 bit value
    function automatic logic signed [15:0] sat_quot(input logic neg, input logic ovf,
                                                    input logic [QUOT_BITS-1:0] q);
        logic signed [15:0] v;
        if (!neg)
        begin
            if (ovf || q > 17'd32767)
                v = 16'sh7FFF;
            else
                v = q[15:0];
        end
        else
        begin
            if (ovf || q > 17'd32768)
                v = 16'sh8000;
            else
                v = (~q[15:0]) + 16'd1;
        end
        return v;
    endfunction

endpackage

// ----- sv/erp_trig.sv -----
// sine / cosine sequencer: one shared cordic unit, steps the three angles in turn
// depends on erp_pkg
module erp_trig import erp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restart,
    input  logic [15:0] angle_x,
    input  logic [15:0] angle_y,
    input  logic [15:0] angle_z,
    output logic        busy,
    output trig_set_t   trig
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_ITER = 4'b0100,
        ST_DONE = 4'b1000
    } trig_state_t;

    trig_state_t        state_reg, state_next;
    logic [1:0]         axis_reg, axis_next;
    logic [3:0]         step_reg, step_next;
    logic               neg_reg, neg_next;
    logic signed [33:0] cx_reg, cx_next;
    logic signed [33:0] cy_reg, cy_next;
    logic signed [25:0] cz_reg, cz_next;
    trig_val_t          sin_reg [0:2];
    trig_val_t          cos_reg [0:2];
    trig_val_t          sin_next [0:2];
    trig_val_t          cos_next [0:2];

    logic [15:0]        angle_sel;
    logic signed [16:0] a_raw;
    logic signed [16:0] a_adj;
    logic               a_neg;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [25:0] at;
    logic signed [33:0] rc;
    logic signed [33:0] rs;
    trig_val_t          cv;
    trig_val_t          sv;

    function automatic trig_val_t clamp_trig(input logic signed [33:0] v);
        trig_val_t r;
        if (v > 34'sd16384)
            r = 16'sd16384;
        else if (v < -34'sd16384)
            r = -16'sd16384;
        else
            r = v[15:0];
        return r;
    endfunction

    always_comb
    begin
        case (axis_reg)
            2'd0:    angle_sel = angle_x;
            2'd1:    angle_sel = angle_y;
            default: angle_sel = angle_z;
        endcase
        a_raw = {angle_sel[15], angle_sel};
        a_neg = 1'b0;
        a_adj = a_raw;
        // fold beyond a quarter turn by a half turn, negate at the end
        if (a_raw > 17'sd16384)
        begin
            a_adj = a_raw - 17'sd32768;
            a_neg = 1'b1;
        end
        else if (a_raw < -17'sd16384)
        begin
            a_adj = a_raw + 17'sd32768;
            a_neg = 1'b1;
        end

        dx = cy_reg >>> step_reg;
        dy = cx_reg >>> step_reg;
        at = {4'b0000, atan_lut(step_reg)};

        rc = (cx_reg + 34'sd32768) >>> 16;
        rs = (cy_reg + 34'sd32768) >>> 16;
        cv = clamp_trig(rc);
        sv = clamp_trig(rs);
        if (neg_reg)
        begin
            cv = -cv;
            sv = -sv;
        end

        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        for (int i = 0; i < 3; i++)
        begin
            sin_next[i] = sin_reg[i];
            cos_next[i] = cos_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                neg_next   = a_neg;
                cx_next    = CORDIC_GAIN;
                cy_next    = '0;
                cz_next    = {a_adj[16], a_adj, 8'b0};
                step_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                if (!cz_reg[25])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - at;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + at;
                end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(CORDIC_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                sin_next[axis_reg] = sv;
                cos_next[axis_reg] = cv;
                if (axis_reg == 2'd2)
                    state_next = ST_IDLE;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (restart)
        begin
            axis_next  = 2'd0;
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            axis_reg  <= 2'd0;
            step_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        cz_reg  <= cz_next;
        for (int i = 0; i < 3; i++)
        begin
            sin_reg[i] <= sin_next[i];
            cos_reg[i] <= cos_next[i];
        end
    end

    assign busy = (state_reg != ST_IDLE) || restart;

    assign trig.sin_x = sin_reg[0];
    assign trig.cos_x = cos_reg[0];
    assign trig.sin_y = sin_reg[1];
    assign trig.cos_y = cos_reg[1];
    assign trig.sin_z = sin_reg[2];
    assign trig.cos_z = cos_reg[2];

endmodule

// ----- sv/erp_rotate.sv -----
// three rotation stages: about x, then y, then z, one register stage each
// depends on erp_pkg
module erp_rotate import erp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               valid_in,
    input  logic signed [15:0] vx,
    input  logic signed [15:0] vy,
    input  logic signed [15:0] vz,
    input  trig_set_t          trig,
    output logic               valid_out,
    output coord_t             x_out,
    output coord_t             y_out,
    output coord_t             z_out
);

    logic      v1_reg, v2_reg, v3_reg;
    coord_t    x1_reg, y1_reg, z1_reg;
    coord_t    x2_reg, y2_reg, z2_reg;
    coord_t    x3_reg, y3_reg, z3_reg;
    rot_pair_t r1_next, r2_next, r3_next;

    always_comb
    begin
        r1_next = rot_pair(coord_t'(vy), coord_t'(vz), trig.sin_x, trig.cos_x);
        // (z, x) pair gives z' first, x' second
        r2_next = rot_pair(z1_reg, x1_reg, trig.sin_y, trig.cos_y);
        r3_next = rot_pair(x2_reg, y2_reg, trig.sin_z, trig.cos_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= coord_t'(vx);
            y1_reg <= r1_next.first;
            z1_reg <= r1_next.second;
            z2_reg <= r2_next.first;
            x2_reg <= r2_next.second;
            y2_reg <= y1_reg;
            x3_reg <= r3_next.first;
            y3_reg <= r3_next.second;
            z3_reg <= z2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign x_out     = x3_reg;
    assign y_out     = y3_reg;
    assign z_out     = z3_reg;

endmodule

// ----- sv/erp_project.sv -----
// perspective numerators and denominator: three stages ending in a magnitude and sign
// depends on erp_pkg
module erp_project import erp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             valid_in,
    input  coord_t           x_in,
    input  coord_t           y_in,
    input  coord_t           z_in,
    input  logic [15:0]      view_distance,
    input  logic [12:0]      screen_width,
    input  logic [12:0]      screen_height,
    output proj_ctl_t        ctl_out,
    output logic [MAG_W-1:0] mag_x,
    output logic [MAG_W-1:0] mag_y,
    output logic [DEN_W-1:0] den_out
);

    // stage 1: denominator and x*d, -y*d
    logic               p1_valid_reg;
    logic               p1_inval_reg;
    logic signed [21:0] p1_den_reg;
    logic signed [39:0] p1_px_reg;
    logic signed [39:0] p1_py_reg;
    logic signed [21:0] dq;
    logic signed [21:0] den_next;
    logic signed [39:0] dq_e;
    logic signed [39:0] x_e;
    logic signed [39:0] ny_e;

    // stage 2: scale by width / height, center offsets
    logic               p2_valid_reg;
    logic               p2_inval_reg;
    logic [DEN_W-1:0]   p2_den_reg;
    logic signed [53:0] p2_ax_reg;
    logic signed [53:0] p2_ay_reg;
    logic [32:0]        p2_bx_reg;
    logic [32:0]        p2_by_reg;
    logic [DEN_W-1:0]   den_u_next;
    logic signed [53:0] px_e;
    logic signed [53:0] py_e;
    logic signed [53:0] w_e;
    logic signed [53:0] h_e;

    // stage 3: sum, sign, magnitude over 8192
    proj_ctl_t          p3_ctl_reg;
    logic [DEN_W-1:0]   p3_den_reg;
    logic [MAG_W-1:0]   p3_mx_reg;
    logic [MAG_W-1:0]   p3_my_reg;
    logic signed [53:0] nx_next;
    logic signed [53:0] ny_next;
    logic [53:0]        ax_abs;
    logic [53:0]        ay_abs;

    always_comb
    begin
        dq       = {2'b00, view_distance, 4'b0000};
        den_next = dq + 22'(z_in);
        dq_e     = dq;
        x_e      = x_in;
        ny_e     = -(40'(y_in));

        den_u_next = p1_inval_reg ? DEN_W'(1) : p1_den_reg[DEN_W-1:0];
        px_e       = p1_px_reg;
        py_e       = p1_py_reg;
        w_e        = {41'b0, screen_width};
        h_e        = {41'b0, screen_height};

        nx_next = p2_ax_reg + $signed({8'b0, p2_bx_reg, 13'b0});
        ny_next = p2_ay_reg + $signed({8'b0, p2_by_reg, 13'b0});
        ax_abs  = nx_next[53] ? 54'(-nx_next) : 54'(nx_next);
        ay_abs  = ny_next[53] ? 54'(-ny_next) : 54'(ny_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_ctl_reg   <= '0;
        end
        else if (adv)
        begin
            p1_valid_reg     <= valid_in;
            p2_valid_reg     <= p1_valid_reg;
            p3_ctl_reg.valid   <= p2_valid_reg;
            p3_ctl_reg.invalid <= p2_inval_reg;
            p3_ctl_reg.neg_x   <= nx_next[53];
            p3_ctl_reg.neg_y   <= ny_next[53];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_den_reg   <= den_next;
            p1_inval_reg <= den_next[21] || (den_next == 22'sd0);
            p1_px_reg    <= x_e * dq_e;
            p1_py_reg    <= ny_e * dq_e;

            p2_inval_reg <= p1_inval_reg;
            p2_den_reg   <= den_u_next;
            p2_ax_reg    <= px_e * w_e;
            p2_ay_reg    <= py_e * h_e;
            p2_bx_reg    <= {21'b0, screen_width[12:1]} * {12'b0, den_u_next};
            p2_by_reg    <= {21'b0, screen_height[12:1]} * {12'b0, den_u_next};

            p3_den_reg <= p2_den_reg;
            p3_mx_reg  <= ax_abs[53:13];
            p3_my_reg  <= ay_abs[53:13];
        end
    end

    assign ctl_out = p3_ctl_reg;
    assign mag_x   = p3_mx_reg;
    assign mag_y   = p3_my_reg;
    assign den_out = p3_den_reg;

endmodule

// ----- sv/erp_divide.sv -----
// pipelined restoring divider, two lanes sharing a divisor, one quotient bit per stage
// depends on erp_pkg
module erp_divide import erp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  proj_ctl_t            ctl_in,
    input  logic [MAG_W-1:0]     mag_x,
    input  logic [MAG_W-1:0]     mag_y,
    input  logic [DEN_W-1:0]     den,
    output proj_ctl_t            ctl_out,
    output logic                 ovf_x,
    output logic                 ovf_y,
    output logic [QUOT_BITS-1:0] quot_x,
    output logic [QUOT_BITS-1:0] quot_y
);

    proj_ctl_t            ctl_reg [0:DIV_STAGES-1];
    logic [DEN_W-1:0]     den_reg [0:DIV_STAGES-1];
    logic [MAG_W-1:0]     rem_reg [0:DIV_STAGES-1][0:1];
    logic [QUOT_BITS-1:0] q_reg   [0:DIV_STAGES-1][0:1];
    logic                 ovf_reg [0:DIV_STAGES-1][0:1];

    logic [MAG_W-1:0]     top_den;
    logic [MAG_W-1:0]     mag_in [0:1];

    // a quotient that reaches 2^17 saturates either way
    assign top_den   = MAG_W'({den, {QUOT_BITS{1'b0}}});
    assign mag_in[0] = mag_x;
    assign mag_in[1] = mag_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (adv)
            ctl_reg[0] <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0] <= den;
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= mag_in[l];
                q_reg[0][l]   <= '0;
                ovf_reg[0][l] <= (mag_in[l] >= top_den);
            end
        end
    end

    for (genvar s = 1; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int K = DIV_STAGES - 1 - s;
        logic [MAG_W-1:0] dsh;
        logic             ge_next [0:1];
        logic [MAG_W-1:0] rem_next [0:1];

        always_comb
        begin
            dsh = MAG_W'(den_reg[s-1]) << K;
            for (int l = 0; l < 2; l++)
            begin
                ge_next[l]  = rem_reg[s-1][l] >= dsh;
                rem_next[l] = ge_next[l] ? rem_reg[s-1][l] - dsh : rem_reg[s-1][l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[s] <= '0;
            else if (adv)
                ctl_reg[s] <= ctl_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[s] <= den_reg[s-1];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[s][l] <= rem_next[l];
                    q_reg[s][l]   <= {q_reg[s-1][l][QUOT_BITS-2:0], ge_next[l]};
                    ovf_reg[s][l] <= ovf_reg[s-1][l];
                end
            end
        end
    end

    assign ctl_out = ctl_reg[DIV_STAGES-1];
    assign ovf_x   = ovf_reg[DIV_STAGES-1][0];
    assign ovf_y   = ovf_reg[DIV_STAGES-1][1];
    assign quot_x  = q_reg[DIV_STAGES-1][0];
    assign quot_y  = q_reg[DIV_STAGES-1][1];

endmodule

// ----- sv/euler_rotate_perspective_project.sv -----
// top level: config registers, trig sequencer, rotate / project / divide pipeline, output beat
// depends on erp_pkg, erp_trig, erp_rotate, erp_project, erp_divide

// Rotates each vertex (signed q3.12) about x, then y, then z by the configured binary
// angles, applies the perspective factor d/(d+z) and maps the result to pixels with y
// flipped, truncating toward zero and saturating to 16 bits; a denominator at or below
// zero gives screen 0,0 with invalid_depth set. One vertex beat is taken every cycle
// while in_stall is low. From input beat to output beat it passes three rotation stages,
// three projection stages, eighteen divider stages (an overflow check, then one quotient
// bit each) and the output register. Sine and cosine come from a single shared 16-step
// cordic that runs after reset and after every angle write: it walks the three angles
// in turn, and in_stall stays high while it runs. Config writes are taken at any time.
module euler_rotate_perspective_project import erp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // config write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    // vertex input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] vertex_x,
    input  logic signed [15:0] vertex_y,
    input  logic signed [15:0] vertex_z,

    // screen output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic               invalid_depth
);

    // config registers
    logic [15:0] angle_x_reg;
    logic [15:0] angle_y_reg;
    logic [15:0] angle_z_reg;
    logic [15:0] view_distance_reg;
    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;

    // pipeline control: every stage moves unless the output beat is held
    logic adv;
    logic in_accept;
    logic angle_write;
    logic trig_busy;
    trig_set_t trig;

    // rotate -> project
    logic   rot_valid;
    coord_t rot_x;
    coord_t rot_y;
    coord_t rot_z;

    // project -> divide
    proj_ctl_t        proj_ctl;
    logic [MAG_W-1:0] proj_mx;
    logic [MAG_W-1:0] proj_my;
    logic [DEN_W-1:0] proj_den;

    // divide -> output
    proj_ctl_t            div_ctl;
    logic                 div_ovf_x;
    logic                 div_ovf_y;
    logic [QUOT_BITS-1:0] div_qx;
    logic [QUOT_BITS-1:0] div_qy;

    // output beat
    logic               out_valid_reg;
    logic signed [15:0] screen_x_reg, screen_x_next;
    logic signed [15:0] screen_y_reg, screen_y_next;
    logic               invalid_reg;

    assign adv         = !(out_valid_reg && out_stall);
    assign angle_write = cfg_we && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y
                                    || cfg_index == REG_ANGLE_Z);
    // hold off vertices until sin / cos match the angle registers
    assign in_stall    = !adv || trig_busy;
    assign in_accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg       <= 16'd0;
            angle_y_reg       <= 16'd0;
            angle_z_reg       <= 16'd0;
            view_distance_reg <= 16'd5120;
            screen_width_reg  <= 13'd800;
            screen_height_reg <= 13'd600;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_X:       angle_x_reg       <= cfg_data;
                REG_ANGLE_Y:       angle_y_reg       <= cfg_data;
                REG_ANGLE_Z:       angle_z_reg       <= cfg_data;
                REG_VIEW_DISTANCE: view_distance_reg <= cfg_data;
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[12:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[12:0];
                default:           ;
            endcase
        end
    end

    // sin / cos of the three angles, recomputed on every angle write
    erp_trig u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (angle_write),
        .angle_x (angle_x_reg),
        .angle_y (angle_y_reg),
        .angle_z (angle_z_reg),
        .busy    (trig_busy),
        .trig    (trig)
    );

    erp_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (in_accept),
        .vx        (vertex_x),
        .vy        (vertex_y),
        .vz        (vertex_z),
        .trig      (trig),
        .valid_out (rot_valid),
        .x_out     (rot_x),
        .y_out     (rot_y),
        .z_out     (rot_z)
    );

    erp_project u_project (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .valid_in      (rot_valid),
        .x_in          (rot_x),
        .y_in          (rot_y),
        .z_in          (rot_z),
        .view_distance (view_distance_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .ctl_out       (proj_ctl),
        .mag_x         (proj_mx),
        .mag_y         (proj_my),
        .den_out       (proj_den)
    );

    erp_divide u_divide (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_in  (proj_ctl),
        .mag_x   (proj_mx),
        .mag_y   (proj_my),
        .den     (proj_den),
        .ctl_out (div_ctl),
        .ovf_x   (div_ovf_x),
        .ovf_y   (div_ovf_y),
        .quot_x  (div_qx),
        .quot_y  (div_qy)
    );

    // sign, saturation, and zeroing for a bad depth
    always_comb
    begin
        screen_x_next = sat_quot(div_ctl.neg_x, div_ovf_x, div_qx);
        screen_y_next = sat_quot(div_ctl.neg_y, div_ovf_y, div_qy);
        if (div_ctl.invalid)
        begin
            screen_x_next = '0;
            screen_y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            screen_x_reg <= screen_x_next;
            screen_y_reg <= screen_y_next;
            invalid_reg  <= div_ctl.invalid;
        end
    end

    assign out_valid     = out_valid_reg;
    assign screen_x      = screen_x_reg;
    assign screen_y      = screen_y_reg;
    assign invalid_depth = invalid_reg;

endmodule

// ----- sv/erp_checker.sv -----
// port-level checks for the euler rotate / project block, attached by bind
// depends on erp_pkg and euler_rotate_perspective_project
module erp_checker import erp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_we,
    input logic [2:0]         cfg_index,
    input logic [15:0]        cfg_data,
    input logic               in_valid,
    input logic               in_stall,
    input logic signed [15:0] vertex_x,
    input logic signed [15:0] vertex_y,
    input logic signed [15:0] vertex_z,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] screen_x,
    input logic signed [15:0] screen_y,
    input logic               invalid_depth
);

    // a held output beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // a held output beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(screen_x) && $stable(screen_y)
                                   && $stable(invalid_depth))
        else $error("output payload changed while stalled");

    // a bad depth beat carries a zero screen position
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid_depth |-> screen_x == 16'sd0 && screen_y == 16'sd0)
        else $error("invalid depth beat with nonzero position");

    // an angle write holds off vertices while sin / cos are refreshed
    a_angle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y
                   || cfg_index == REG_ANGLE_Z) |=> in_stall)
        else $error("vertex taken right after an angle write");

endmodule

bind euler_rotate_perspective_project erp_checker u_erp_checker (.*);

// ----- verif/erp_checker.sv -----
// vertex-to-screen predictor and result checker for euler_rotate_perspective_project
// depends on erp_pkg; watches the config port and both beat channels
`timescale 1ns / 1ps

module erp_scoreboard import erp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] vertex_x,
    input  logic signed [15:0] vertex_y,
    input  logic signed [15:0] vertex_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] screen_x,
    input  logic signed [15:0] screen_y,
    input  logic               invalid_depth,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               bad;
    } screen_pt_t;

    screen_pt_t pixel_queue[$];

    logic [15:0] ang_x, ang_y, ang_z, view_dist;
    logic [12:0] width, height;

    localparam longint ATAN[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                    41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                    163, 81};

    function automatic longint rnd_shift(input longint v, input int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    // 16-step cordic, angle folded into +-quarter turn
    function automatic void sin_cos(input logic [15:0] ang, output longint s,
                                    output longint c);
        longint a, x, y, z, dx, dy;
        bit     flip;
        a = longint'(signed'(ang));
        flip = 0;
        if (a > 16384)
        begin
            a -= 32768;
            flip = 1;
        end
        else if (a < -16384)
        begin
            a += 32768;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = a * 256;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN[i];
            end
        end
        x = clamp_unit(rnd_shift(x, 16));
        y = clamp_unit(rnd_shift(y, 16));
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic screen_pt_t project_vertex(input logic signed [15:0] vx,
                                                  input logic signed [15:0] vy,
                                                  input logic signed [15:0] vz);
        longint x, y, z, s, c, t1, t2, dq, den, w, h, q;
        screen_pt_t p;
        x = vx;
        y = vy;
        z = vz;
        sin_cos(ang_x, s, c);
        t1 = rnd_shift(y * c - z * s, 14);
        t2 = rnd_shift(y * s + z * c, 14);
        y = t1;
        z = t2;
        sin_cos(ang_y, s, c);
        t1 = rnd_shift(x * c + z * s, 14);
        t2 = rnd_shift(z * c - x * s, 14);
        x = t1;
        z = t2;
        sin_cos(ang_z, s, c);
        t1 = rnd_shift(x * c - y * s, 14);
        t2 = rnd_shift(x * s + y * c, 14);
        x = t1;
        y = t2;
        dq = longint'(view_dist) * 16;
        den = dq + z;
        if (den <= 0)
        begin
            p.sx = 0;
            p.sy = 0;
            p.bad = 1;
            return p;
        end
        w = width;
        h = height;
        q = 2 * 4096 * den;
        p.sx = sat16((x * dq * w + (w / 2) * q) / q);
        p.sy = sat16((-y * dq * h + (h / 2) * q) / q);
        p.bad = 0;
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        screen_pt_t want;
        if (!rst_n)
        begin
            ang_x <= 16'd0;
            ang_y <= 16'd0;
            ang_z <= 16'd0;
            view_dist <= 16'd5120;
            width <= 13'd800;
            height <= 13'd600;
            fail_count <= 0;
            pending <= 0;
            pixel_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ANGLE_X:       ang_x <= cfg_data;
                    REG_ANGLE_Y:       ang_y <= cfg_data;
                    REG_ANGLE_Z:       ang_z <= cfg_data;
                    REG_VIEW_DISTANCE: view_dist <= cfg_data;
                    REG_SCREEN_WIDTH:  width <= cfg_data[12:0];
                    REG_SCREEN_HEIGHT: height <= cfg_data[12:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                pixel_queue.insert(pixel_queue.size(),
                                   project_vertex(vertex_x, vertex_y, vertex_z));
            if (out_valid && !out_stall)
            begin
                if (pixel_queue.size() == 0)
                begin
                    $display("%0t: unexpected beat sx=%0d sy=%0d inv=%0b", $time,
                             screen_x, screen_y, invalid_depth);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (want.sx !== screen_x || want.sy !== screen_y
                        || want.bad !== invalid_depth)
                    begin
                        $display("%0t: screen_x expected %0d actual %0d", $time,
                                 want.sx, screen_x);
                        $display("%0t: screen_y expected %0d actual %0d", $time,
                                 want.sy, screen_y);
                        $display("%0t: invalid_depth expected %0b actual %0b", $time,
                                 want.bad, invalid_depth);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= pixel_queue.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
// stimulus and verdict for euler_rotate_perspective_project
// depends on erp_pkg, the block under test and erp_scoreboard
`timescale 1ns / 1ps

module testbench import erp_pkg::*;
();

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] vertex_x, vertex_y, vertex_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] screen_x, screen_y;
    logic               invalid_depth;
    int                 fail_count;
    int                 pending;

    // idle odds out of a hundred for each side
    int                 send_idle;
    int                 recv_idle;
    int                 sent;

    euler_rotate_perspective_project dut (.*);

    erp_scoreboard checker_i (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // receiver stall, redrawn every cycle
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // hard stop in case the pipeline wedges
    initial
    begin
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

    // back-to-back register writes keep cfg_we high, no dip within a step
    task automatic write_regs(input logic [15:0] vals[6]);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // one vertex beat, held until the block takes it
    task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        vertex_x <= x;
        vertex_y <= y;
        vertex_z <= z;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        // idling mode follows progress through the run
        if (sent < 350)
        begin
            send_idle = 8;
            recv_idle = 66;
        end
        else if (sent < 700)
        begin
            send_idle = 66;
            recv_idle = 8;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    // empty pipeline before touching config: wait out the checker queue, then latency
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(255) - 128);
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(7))
            0:       return 16'h4000;
            1:       return 16'hC000;
            2:       return 16'h4001;
            3:       return 16'h8000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        logic [15:0] cfg_set[6];
        logic [15:0] corner[3];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        vertex_x = '0;
        vertex_y = '0;
        vertex_z = '0;
        out_stall = 1'b0;
        send_idle = 8;
        recv_idle = 66;
        sent = 0;
        corner = '{16'h8000, 16'h7FFF, 16'h0000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: coordinate extremes at reset config, includes near-plane z
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                send_vertex(corner[a], corner[b], corner[(a + b) % 3]);
        send_vertex(16'h0000, 16'h0000, 16'h0000);
        send_vertex(16'h1000, 16'hF000, 16'h8000);
        drain();

        // directed: tiny distance so depth goes invalid, extreme screen sizes
        cfg_set = '{16'hFFFF, 16'h8000, 16'h4000, 16'd1, 16'd4096, 16'd1};
        write_regs(cfg_set);
        for (int a = 0; a < 3; a++)
            send_vertex(corner[a], corner[(a + 1) % 3], corner[(a + 2) % 3]);
        send_vertex(16'h0000, 16'h0000, 16'h0001);
        send_vertex(16'h0000, 16'h0000, 16'hFFFF);
        drain();

        // directed: far viewer, opposite screen extremes, quarter-turn boundaries
        cfg_set = '{16'h4001, 16'hC000, 16'h3FFF, 16'hFFFF, 16'd1, 16'd4096};
        write_regs(cfg_set);
        for (int a = 0; a < 3; a++)
            send_vertex(corner[a], corner[a], corner[(a + 1) % 3]);
        drain();

        // random phases, each with its own config
        for (int ph = 0; ph < 10; ph++)
        begin
            cfg_set[0] = rand_angle();
            cfg_set[1] = rand_angle();
            cfg_set[2] = rand_angle();
            // small distance half the time so invalid depth shows up often
            cfg_set[3] = 16'($urandom_range(1) ? $urandom_range(400, 1)
                                               : $urandom_range(65535, 1));
            cfg_set[4] = 16'($urandom_range(4096, 1));
            cfg_set[5] = 16'($urandom_range(4096, 1));
            write_regs(cfg_set);
            repeat (103)
                send_vertex(rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
